// ===== sv/m68mi_pkg.sv =====
// Package for the 6800 accumulator and flag instruction unit.
// It holds the opcode and mode codes, flag bit positions and transaction payload types.
// It has no dependencies and is compiled first.
package m68mi_pkg;

    typedef enum logic [3:0] {
        OP_CLC  = 4'd0,
        OP_CLI  = 4'd1,
        OP_NOP  = 4'd2,
        OP_SEC  = 4'd3,
        OP_SEI  = 4'd4,
        OP_TAB  = 4'd5,
        OP_TAP  = 4'd6,
        OP_TBA  = 4'd7,
        OP_TPA  = 4'd8,
        OP_NEGA = 4'd9,
        OP_NEGB = 4'd10,
        OP_NEGM = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        MODE_INH   = 2'd0,
        MODE_IDX   = 2'd1,
        MODE_EXT   = 2'd2,
        MODE_OTHER = 2'd3
    } mode_t;

    // Bit positions in the condition-code byte.
    localparam int FLAG_C = 0;
    localparam int FLAG_V = 1;
    localparam int FLAG_Z = 2;
    localparam int FLAG_N = 3;
    localparam int FLAG_I = 4;

    // The only operand whose negation overflows.
    localparam logic [7:0] NEG_OVF_VALUE = 8'h80;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] access_mode;
        logic [7:0] mem_value;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] acc_a;
        logic [7:0] acc_b;
        logic [7:0] cond_codes;
        logic       mem_write;
        logic [7:0] mem_result;
    } rsp_t;

endpackage

// ===== sv/m68mi_ifs.sv =====
// Valid/ready channel interfaces for the instruction and result transactions.
// Payload fields follow the types in m68mi_pkg.
interface m68mi_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic [1:0] access_mode;
    logic [7:0] mem_value;

    modport source (output valid, output op, output access_mode, output mem_value, input ready);
    modport sink   (input valid, input op, input access_mode, input mem_value, output ready);
endinterface

interface m68mi_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] acc_a;
    logic [7:0] acc_b;
    logic [7:0] cond_codes;
    logic       mem_write;
    logic [7:0] mem_result;

    modport source (output valid, output ok, output acc_a, output acc_b, output cond_codes,
                    output mem_write, output mem_result, input ready);
    modport sink   (input valid, input ok, input acc_a, input acc_b, input cond_codes,
                    input mem_write, input mem_result, output ready);
endinterface

// ===== sv/m68mi_exec.sv =====
// Execute stage: holds accumulators A, B and the condition codes and applies one instruction.
// Depends on m68mi_pkg for opcode, mode and flag definitions.
module m68mi_exec
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  m68mi_pkg::cmd_t cmd,
    output m68mi_pkg::rsp_t rsp
);

    logic [7:0] acc_a_reg, acc_a_next;
    logic [7:0] acc_b_reg, acc_b_next;
    logic [7:0] flags_reg, flags_next;

    logic       pair_ok;
    logic [7:0] neg_in;
    logic [7:0] neg_res;
    logic [7:0] neg_flags;
    logic [7:0] mov_val;
    logic [7:0] mov_flags;

    always_comb
    begin
        if (cmd.op == m68mi_pkg::OP_NEGM)
        begin
            pair_ok = (cmd.access_mode == m68mi_pkg::MODE_IDX) ||
                      (cmd.access_mode == m68mi_pkg::MODE_EXT);
        end
        else
        begin
            pair_ok = (cmd.op <= m68mi_pkg::OP_NEGB) &&
                      (cmd.access_mode == m68mi_pkg::MODE_INH);
        end
    end

    // Shared negate unit: its operand is A, B or the memory byte.
    always_comb
    begin
        case (cmd.op)
            m68mi_pkg::OP_NEGA: neg_in = acc_a_reg;
            m68mi_pkg::OP_NEGB: neg_in = acc_b_reg;
            default:            neg_in = cmd.mem_value;
        endcase
        neg_res = ~neg_in + 8'd1;
        neg_flags = flags_reg;
        neg_flags[m68mi_pkg::FLAG_C] = (neg_in != 8'd0);
        neg_flags[m68mi_pkg::FLAG_V] = (neg_in == m68mi_pkg::NEG_OVF_VALUE);
        neg_flags[m68mi_pkg::FLAG_N] = neg_res[7];
        neg_flags[m68mi_pkg::FLAG_Z] = (neg_res == 8'd0);
    end

    // Transfers between accumulators set N and Z from the byte moved and clear V.
    always_comb
    begin
        mov_val = (cmd.op == m68mi_pkg::OP_TAB) ? acc_a_reg : acc_b_reg;
        mov_flags = flags_reg;
        mov_flags[m68mi_pkg::FLAG_N] = mov_val[7];
        mov_flags[m68mi_pkg::FLAG_Z] = (mov_val == 8'd0);
        mov_flags[m68mi_pkg::FLAG_V] = 1'b0;
    end

    always_comb
    begin
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        flags_next     = flags_reg;
        rsp.mem_write  = 1'b0;
        rsp.mem_result = 8'd0;
        if (pair_ok)
        begin
            case (cmd.op)
                m68mi_pkg::OP_CLC:  flags_next[m68mi_pkg::FLAG_C] = 1'b0;
                m68mi_pkg::OP_CLI:  flags_next[m68mi_pkg::FLAG_I] = 1'b0;
                m68mi_pkg::OP_SEC:  flags_next[m68mi_pkg::FLAG_C] = 1'b1;
                m68mi_pkg::OP_SEI:  flags_next[m68mi_pkg::FLAG_I] = 1'b1;
                m68mi_pkg::OP_TAB:
                begin
                    acc_b_next = mov_val;
                    flags_next = mov_flags;
                end
                m68mi_pkg::OP_TAP:  flags_next = acc_a_reg;
                m68mi_pkg::OP_TBA:
                begin
                    acc_a_next = mov_val;
                    flags_next = mov_flags;
                end
                m68mi_pkg::OP_TPA:  acc_a_next = flags_reg;
                m68mi_pkg::OP_NEGA:
                begin
                    acc_a_next = neg_res;
                    flags_next = neg_flags;
                end
                m68mi_pkg::OP_NEGB:
                begin
                    acc_b_next = neg_res;
                    flags_next = neg_flags;
                end
                m68mi_pkg::OP_NEGM:
                begin
                    flags_next     = neg_flags;
                    rsp.mem_write  = 1'b1;
                    rsp.mem_result = neg_res;
                end
                default:
                begin
                end
            endcase
        end
        rsp.ok         = pair_ok;
        rsp.acc_a      = acc_a_next;
        rsp.acc_b      = acc_b_next;
        rsp.cond_codes = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_a_reg <= 8'd0;
            acc_b_reg <= 8'd0;
            flags_reg <= 8'd0;
        end
        else if (fire)
        begin
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
            flags_reg <= flags_next;
        end
    end

endmodule

// ===== sv/m68mi_skid.sv =====
// Result register with a skid entry, driving the result channel.
// Depends on m68mi_pkg for the result type and m68mi_ifs for the channel.
module m68mi_skid
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  m68mi_pkg::rsp_t push_data,
    output logic            can_push,
    m68mi_rsp_if.source     rsp
);

    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    m68mi_pkg::rsp_t out_data_reg, out_data_next;
    m68mi_pkg::rsp_t skid_data_reg, skid_data_next;
    logic            take;

    assign take     = out_valid_reg && rsp.ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_data_reg.ok;
    assign rsp.acc_a      = out_data_reg.acc_a;
    assign rsp.acc_b      = out_data_reg.acc_b;
    assign rsp.cond_codes = out_data_reg.cond_codes;
    assign rsp.mem_write  = out_data_reg.mem_write;
    assign rsp.mem_result = out_data_reg.mem_result;

endmodule

// ===== sv/m6800_misc_inherent_ops.sv =====
// Top level of the 6800 accumulator and flag instruction unit.
// Depends on m68mi_pkg, m68mi_ifs, m68mi_exec and m68mi_skid.
//
// This block executes CLC, CLI, NOP, SEC, SEI, TAB, TAP, TBA, TPA, NEGA, NEGB and
// NEG on a memory byte against its own accumulators A and B and the condition-code
// byte, all cleared by reset. Each accepted instruction transaction produces exactly
// one result transaction carrying ok, the accumulators and flags after the step, and
// for a successful NEG memory the negated byte with mem_write set. An instruction in
// an unsupported addressing mode, or an unused opcode, returns ok low and leaves the
// state untouched. While results are taken, the block sustains one instruction per clock:
// the state update is a loop through the execute logic, fed from an input register. An
// accepted instruction passes through the input register and then the result register
// before its result is valid on the result channel. The result register has a skid
// entry behind it, so while a result waits to be taken the block keeps accepting
// instructions until the skid entry and the input register are both full, and only
// then stalls the instruction channel.
module m6800_misc_inherent_ops
(
    input  logic        clk,
    input  logic        rst_n,
    m68mi_cmd_if.sink   cmd,
    m68mi_rsp_if.source rsp
);

    // Input register stage.
    logic            s1_valid_reg, s1_valid_next;
    m68mi_pkg::cmd_t s1_cmd_reg;

    logic            advance;
    logic            can_push;
    m68mi_pkg::rsp_t exec_rsp;

    // The registered instruction moves on, and updates the state, whenever the
    // result buffer has room for its result.
    assign advance   = s1_valid_reg && can_push;
    assign cmd.ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd.ready)
        begin
            s1_valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_cmd_reg.op          <= cmd.op;
            s1_cmd_reg.access_mode <= cmd.access_mode;
            s1_cmd_reg.mem_value   <= cmd.mem_value;
        end
    end

    m68mi_exec u_exec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (s1_cmd_reg),
        .rsp   (exec_rsp)
    );

    m68mi_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (exec_rsp),
        .can_push  (can_push),
        .rsp       (rsp)
    );

endmodule

// ===== sv/m68mi_check.sv =====
// Port-level checker for m6800_misc_inherent_ops, with the bind that attaches it.
// Depends on the top level's ports only.
module m68mi_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_ok,
    input logic [7:0] rsp_acc_a,
    input logic [7:0] rsp_acc_b,
    input logic [7:0] rsp_cond_codes,
    input logic       rsp_mem_write,
    input logic [7:0] rsp_mem_result
);

    logic       cmd_take;
    logic       rsp_take;
    logic [2:0] pending_reg;
    logic [7:0] prev_a_reg;
    logic [7:0] prev_b_reg;
    logic [7:0] prev_f_reg;

    assign cmd_take = cmd_valid && cmd_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    // Transactions accepted but not yet delivered, and the state last reported.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
            prev_a_reg  <= 8'd0;
            prev_b_reg  <= 8'd0;
            prev_f_reg  <= 8'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {2'd0, cmd_take} - {2'd0, rsp_take};
            if (rsp_take)
            begin
                prev_a_reg <= rsp_acc_a;
                prev_b_reg <= rsp_acc_b;
                prev_f_reg <= rsp_cond_codes;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_acc_a) && $stable(rsp_acc_b)
            && $stable(rsp_cond_codes) && $stable(rsp_mem_result))
        else $error("result changed while stalled");

    a_write_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_mem_write |-> rsp_ok)
        else $error("write-back flagged on a rejected instruction");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_mem_write |-> rsp_mem_result == 8'd0)
        else $error("write-back byte not zero without a write");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && !rsp_ok |-> rsp_acc_a == prev_a_reg && rsp_acc_b == prev_b_reg
            && rsp_cond_codes == prev_f_reg)
        else $error("rejected instruction changed the state");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more transactions in flight than the block can hold");

endmodule

bind m6800_misc_inherent_ops m68mi_check u_m68mi_check
(
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_acc_a      (rsp.acc_a),
    .rsp_acc_b      (rsp.acc_b),
    .rsp_cond_codes (rsp.cond_codes),
    .rsp_mem_write  (rsp.mem_write),
    .rsp_mem_result (rsp.mem_result)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the 6800 accumulator and flag instruction unit.
// It depends on m68mi_pkg, the channel interfaces in m68mi_ifs and the
// m6800_misc_inherent_ops RTL, and predicts and compares every result field.
module tb;

    // Opcodes above NEG memory have no instruction and must come back rejected.
    localparam logic [3:0] OP_UNUSED_LO = 4'd12;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // Cycles with no transaction on either channel before the run is declared hung.
    // The slowest correct stretch is a long sender gap, the pass through the input and
    // result registers and a long result stall back to back.
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 550;
    // Settling time after the last expected result, for any stray result to show.
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        m68mi_pkg::cmd_t cmd;
        bit              drain;
    } send_item_t;

    logic clk;
    logic rst_n;

    m68mi_cmd_if cmd_ch ();
    m68mi_rsp_if rsp_ch ();

    m6800_misc_inherent_ops dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Instructions waiting to be sent, and the results that accepted instructions must produce.
    send_item_t      instr_pending[$];
    m68mi_pkg::rsp_t result_expected[$];

    // Predicted architectural state: accumulators and condition-code byte.
    logic [7:0] model_acc_a;
    logic [7:0] model_acc_b;
    logic [7:0] model_ccr;

    int   error_count;
    int   cycle_count;
    int   idle_cycles;
    int   send_gap;
    int   rsp_hold;
    logic cmd_taken;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Idle lengths: mostly none or short, a few long. Every fourth window, as set by bits
    // 8:7 of the cycle count, has no idling at all so that the block also runs at full rate.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count[8:7] == 2'd0)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // N and Z follow the byte that was just produced or moved.
    function automatic void set_nz(logic [7:0] v);
        model_ccr[m68mi_pkg::FLAG_N] = v[7];
        model_ccr[m68mi_pkg::FLAG_Z] = (v == 8'd0);
    endfunction

    // Two's complement negate. Carry is set for any nonzero operand, and overflow
    // only for the one operand whose negation is itself. The half-carry bit is kept.
    function automatic logic [7:0] negate_with_flags(logic [7:0] x);
        logic [7:0] r;
        r = ~x + 8'd1;
        model_ccr[m68mi_pkg::FLAG_C] = (x != 8'd0);
        model_ccr[m68mi_pkg::FLAG_V] = (x == m68mi_pkg::NEG_OVF_VALUE);
        set_nz(r);
        return r;
    endfunction

    // Applies one instruction to the predicted state and returns the result it must produce.
    // NEG memory is legal only in indexed or extended mode, every other instruction only
    // in inherent mode. A rejected pair reports the untouched state with ok low.
    function automatic m68mi_pkg::rsp_t execute_instruction(m68mi_pkg::cmd_t c);
        m68mi_pkg::rsp_t r;
        r = '0;
        if (c.op == m68mi_pkg::OP_NEGM)
        begin
            if (c.access_mode == m68mi_pkg::MODE_IDX || c.access_mode == m68mi_pkg::MODE_EXT)
            begin
                r.mem_result = negate_with_flags(c.mem_value);
                r.mem_write = 1'b1;
                r.ok = 1'b1;
            end
        end
        else if (c.op < m68mi_pkg::OP_NEGM && c.access_mode == m68mi_pkg::MODE_INH)
        begin
            r.ok = 1'b1;
            case (c.op)
                m68mi_pkg::OP_CLC: model_ccr[m68mi_pkg::FLAG_C] = 1'b0;
                m68mi_pkg::OP_CLI: model_ccr[m68mi_pkg::FLAG_I] = 1'b0;
                m68mi_pkg::OP_SEC: model_ccr[m68mi_pkg::FLAG_C] = 1'b1;
                m68mi_pkg::OP_SEI: model_ccr[m68mi_pkg::FLAG_I] = 1'b1;
                m68mi_pkg::OP_TAB:
                begin
                    model_acc_b = model_acc_a;
                    set_nz(model_acc_b);
                    model_ccr[m68mi_pkg::FLAG_V] = 1'b0;
                end
                // All eight bits go across, including the ones no flag uses.
                m68mi_pkg::OP_TAP: model_ccr = model_acc_a;
                m68mi_pkg::OP_TBA:
                begin
                    model_acc_a = model_acc_b;
                    set_nz(model_acc_a);
                    model_ccr[m68mi_pkg::FLAG_V] = 1'b0;
                end
                // The flags are left alone by TPA.
                m68mi_pkg::OP_TPA: model_acc_a = model_ccr;
                m68mi_pkg::OP_NEGA: model_acc_a = negate_with_flags(model_acc_a);
                m68mi_pkg::OP_NEGB: model_acc_b = negate_with_flags(model_acc_b);
                default: ;
            endcase
        end
        r.acc_a = model_acc_a;
        r.acc_b = model_acc_b;
        r.cond_codes = model_ccr;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    function automatic void add_item(logic [3:0] op, logic [1:0] mode, logic [7:0] value,
                                     bit drain);
        send_item_t it;
        it.cmd.op = op;
        it.cmd.access_mode = mode;
        it.cmd.mem_value = value;
        it.drain = drain;
        instr_pending.push_back(it);
    endfunction

    // Monitor. The result channel is checked before the new prediction is queued, so a
    // result can never be matched against an instruction accepted on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
            cycle_count <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (result_expected.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, {rsp_ch.ok, rsp_ch.acc_a, rsp_ch.acc_b, rsp_ch.cond_codes,
                                     rsp_ch.mem_write, rsp_ch.mem_result});
                    error_count++;
                end
                else
                begin
                    m68mi_pkg::rsp_t exp_rsp;
                    exp_rsp = result_expected.pop_front();
                    check_field("ok", 8'(exp_rsp.ok), 8'(rsp_ch.ok));
                    check_field("acc_a", exp_rsp.acc_a, rsp_ch.acc_a);
                    check_field("acc_b", exp_rsp.acc_b, rsp_ch.acc_b);
                    check_field("cond_codes", exp_rsp.cond_codes, rsp_ch.cond_codes);
                    check_field("mem_write", 8'(exp_rsp.mem_write), 8'(rsp_ch.mem_write));
                    check_field("mem_result", exp_rsp.mem_result, rsp_ch.mem_result);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                result_expected.push_back(execute_instruction('{cmd_ch.op, cmd_ch.access_mode,
                                                               cmd_ch.mem_value}));
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;

            // Watchdog: any transaction on either channel counts as progress.
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Instruction driver. Valid is worked out once per falling edge and assigned once,
    // so a back-to-back transaction keeps it high without a glitch. An item marked for
    // draining is held back until every outstanding result has been taken.
    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = cmd_ch.valid;
            if (cmd_ch.valid && cmd_taken)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (instr_pending.size() > 0 &&
                         !(instr_pending[0].drain && result_expected.size() != 0))
                begin
                    send_item_t it;
                    it = instr_pending.pop_front();
                    cmd_ch.op <= it.cmd.op;
                    cmd_ch.access_mode <= it.cmd.access_mode;
                    cmd_ch.mem_value <= it.cmd.mem_value;
                    next_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
            cmd_ch.valid <= next_valid;
        end
    end

    // Result receiver: ready drops for stalls of random length at any point.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rsp_hold = pick_gap();
            end
        end
    end

    initial
    begin
        logic [3:0] op;
        logic [1:0] mode;

        // Every block input starts at a known value.
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op = m68mi_pkg::OP_NOP;
        cmd_ch.access_mode = m68mi_pkg::MODE_INH;
        cmd_ch.mem_value = 8'd0;
        rsp_ch.ready = 1'b0;
        error_count = 0;
        send_gap = 0;
        rsp_hold = 0;
        model_acc_a = 8'd0;
        model_acc_b = 8'd0;
        model_ccr = 8'd0;

        // Directed part. TPA right after reset loads zero into A so that NEGA sees a
        // zero operand; later TAP copies a byte with the upper unused bits set.
        add_item(m68mi_pkg::OP_TPA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_NEGA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_SEC, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_SEI, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_TPA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_NEGA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_TAB, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_TAP, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_TPA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_CLC, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_CLI, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_NOP, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_NEGB, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        add_item(m68mi_pkg::OP_TBA, m68mi_pkg::MODE_INH, rand_byte(), 1'b0);
        // NEG memory on the overflow operand, zero, one and the top of the byte range.
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_IDX, m68mi_pkg::NEG_OVF_VALUE, 1'b0);
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_EXT, 8'h00, 1'b0);
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_IDX, 8'hFF, 1'b0);
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_EXT, 8'h01, 1'b0);
        // Rejected pairs: wrong mode for each kind of instruction, and unused opcodes.
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_INH, 8'h55, 1'b0);
        add_item(m68mi_pkg::OP_NEGM, m68mi_pkg::MODE_OTHER, 8'hAA, 1'b0);
        add_item(m68mi_pkg::OP_TAB, m68mi_pkg::MODE_IDX, 8'hFF, 1'b0);
        add_item(m68mi_pkg::OP_NOP, m68mi_pkg::MODE_EXT, 8'h00, 1'b0);
        add_item(m68mi_pkg::OP_SEC, m68mi_pkg::MODE_OTHER, 8'h7F, 1'b0);
        add_item(OP_UNUSED_LO, m68mi_pkg::MODE_INH, 8'h80, 1'b0);
        add_item(OP_UNUSED_HI, m68mi_pkg::MODE_INH, 8'h00, 1'b0);

        // Random part. Most transactions are legal so the state keeps evolving; the rest
        // is noise over the whole field range. The first one waits for a full drain.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                op = 4'($urandom_range(0, m68mi_pkg::OP_NEGM));
                if (op == m68mi_pkg::OP_NEGM)
                    mode = 2'($urandom_range(m68mi_pkg::MODE_IDX, m68mi_pkg::MODE_EXT));
                else
                    mode = m68mi_pkg::MODE_INH;
            end
            else
            begin
                op = 4'($urandom_range(0, OP_UNUSED_HI));
                mode = 2'($urandom_range(m68mi_pkg::MODE_INH, m68mi_pkg::MODE_OTHER));
            end
            add_item(op, mode, rand_byte(), (i == 0) || ($urandom_range(0, 99) == 0));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last instruction to go out and its result to come back, then
        // give the pipeline a few more cycles to show any stray result.
        while (instr_pending.size() != 0 || cmd_ch.valid || result_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
